// ===== src/vsp_pkg.sv =====
// shared types, constants and helpers for the varispeed sample player
package vsp_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // multiplier operand and result widths
    localparam int MUL_A_W = (SAMPLE_BITS + 2 > 18) ? SAMPLE_BITS + 2 : 18;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // interpolated sample in Q16 and the gain-scaled value
    localparam int Q16_W   = SAMPLE_BITS + 18;
    localparam int SCALE_W = SAMPLE_BITS + 3;
    localparam int TOTAL_W = PROD_W + 17;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [16:0] GAIN_MAX    = 17'h10000;
    localparam logic [15:0] PITCH_MIN   = 16'd8192;
    localparam logic [15:0] PITCH_MAX   = 16'd32768;
    localparam logic [15:0] PITCH_UNITY = 16'd16384;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RENDER = 2'd1,
        OP_SEEK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN         = 3'd0,
        CFG_PITCH        = 3'd1,
        CFG_SAMPLE_COUNT = 3'd2,
        CFG_CLIP_START   = 3'd3,
        CFG_CLIP_LENGTH  = 3'd4,
        CFG_PLAY_ENABLE  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEEK_SUB,
        ST_SEEK_SET,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_GAIN_LO,
        ST_GAIN_HI,
        ST_GAIN_SUM,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_S0,
        MUL_S1,
        MUL_GAIN_LO,
        MUL_GAIN_HI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_UNITY,
        ACC_LOAD,
        ACC_ADD
    } acc_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     seek_sub;
        logic     seek_set;
        logic     rd_en;
        logic     rd_next;
        logic     ld_sound;
        logic     ld_s0;
        mul_sel_t mul_sel;
        acc_sel_t acc_sel;
        logic     ld_lo;
        logic     ld_scale;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic sound;
        logic unity;
        logic out_free;
    } status_t;

    // clamp a 16-bit written value to the stored sample width
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [15:0] v
    );
        int x;
        int hi;
        int lo;
        x  = int'(v);
        hi = (1 << (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
        begin
            x = hi;
        end
        if (x < lo)
        begin
            x = lo;
        end
        return SAMPLE_BITS'(x);
    endfunction

endpackage

// ===== src/varispeed_sample_player_core.sv =====
// top level of the varispeed sample player: stream ports, controller and datapath
// after a write the next request is taken; a seek first runs ST_SEEK_SUB and ST_SEEK_SET
// render: ST_RD_LO, ST_RD_HI, off unity ST_MUL_LO, ST_MUL_HI, ST_ACC, then ST_GAIN_LO,
// ST_GAIN_HI, ST_GAIN_SUM, ST_OUT until out_free, then idle; a silent clip skips to ST_OUT
// off unity: two reads of the single-port store and four passes through one multiplier
// reset clears control, configuration (gain 1.0, pitch 1.0, rest 0) and the read position
module varispeed_sample_player_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // operation, sample_address, sample_value, mix_left_in, mix_right_in,
    // timeline_position, zero fill
    input  logic [vsp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // mix_left_out, mix_right_out, clip_sounding, zero fill
    output logic [vsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [vsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    vsp_pkg::cmd_t      cmd;
    vsp_pkg::status_t   status;
    vsp_pkg::op_t       in_op;
    logic               in_accept;
    logic signed [15:0] out_l;
    logic signed [15:0] out_r;
    logic               out_snd;

    assign in_op         = vsp_pkg::op_t'(s_axis_tdata[1:0]);
    assign s_axis_tready = cmd.in_ready;
    assign in_accept     = s_axis_tvalid && cmd.in_ready;

    vsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (in_op),
        .status   (status),
        .cmd      (cmd)
    );

    vsp_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_accept            (in_accept),
        .in_op                (in_op),
        .in_sample_address    (s_axis_tdata[17:2]),
        .in_sample_value      ($signed(s_axis_tdata[33:18])),
        .in_mix_left          ($signed(s_axis_tdata[49:34])),
        .in_mix_right         ($signed(s_axis_tdata[65:50])),
        .in_timeline_position (s_axis_tdata[97:66]),
        .cmd                  (cmd),
        .status               (status),
        .out_ready            (m_axis_tready),
        .out_valid            (m_axis_tvalid),
        .out_mix_left         (out_l),
        .out_mix_right        (out_r),
        .out_clip_sounding    (out_snd)
    );

    assign m_axis_tdata = {7'd0, out_snd, out_r, out_l};

endmodule

// ===== src/vsp_ctrl.sv =====
// sequencing state machine for write, seek and render requests
module vsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  vsp_pkg::op_t     in_op,
    input  vsp_pkg::status_t status,
    output vsp_pkg::cmd_t    cmd
);

    vsp_pkg::state_t state_reg;
    vsp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vsp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = vsp_pkg::MUL_NONE;
        cmd.acc_sel = vsp_pkg::ACC_NONE;
        unique case (state_reg)
            vsp_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_op)
                        vsp_pkg::OP_RENDER: state_next = vsp_pkg::ST_RD_LO;
                        vsp_pkg::OP_SEEK:   state_next = vsp_pkg::ST_SEEK_SUB;
                        default:            state_next = vsp_pkg::ST_IDLE;
                    endcase
                end
            end
            vsp_pkg::ST_SEEK_SUB:
            begin
                cmd.seek_sub = 1'b1;
                state_next   = vsp_pkg::ST_SEEK_SET;
            end
            vsp_pkg::ST_SEEK_SET:
            begin
                cmd.seek_set = 1'b1;
                state_next   = vsp_pkg::ST_IDLE;
            end
            vsp_pkg::ST_RD_LO:
            begin
                cmd.ld_sound = 1'b1;
                if (status.sound)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = vsp_pkg::ST_RD_HI;
                end
                else
                begin
                    state_next = vsp_pkg::ST_OUT;
                end
            end
            vsp_pkg::ST_RD_HI:
            begin
                cmd.ld_s0 = 1'b1;
                if (status.unity)
                begin
                    // unity pitch takes the sample as it is
                    cmd.acc_sel = vsp_pkg::ACC_UNITY;
                    state_next  = vsp_pkg::ST_GAIN_LO;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = vsp_pkg::ST_MUL_LO;
                end
            end
            vsp_pkg::ST_MUL_LO:
            begin
                cmd.mul_sel = vsp_pkg::MUL_S0;
                state_next  = vsp_pkg::ST_MUL_HI;
            end
            vsp_pkg::ST_MUL_HI:
            begin
                cmd.mul_sel = vsp_pkg::MUL_S1;
                cmd.acc_sel = vsp_pkg::ACC_LOAD;
                state_next  = vsp_pkg::ST_ACC;
            end
            vsp_pkg::ST_ACC:
            begin
                cmd.acc_sel = vsp_pkg::ACC_ADD;
                state_next  = vsp_pkg::ST_GAIN_LO;
            end
            vsp_pkg::ST_GAIN_LO:
            begin
                cmd.mul_sel = vsp_pkg::MUL_GAIN_LO;
                state_next  = vsp_pkg::ST_GAIN_HI;
            end
            vsp_pkg::ST_GAIN_HI:
            begin
                cmd.mul_sel = vsp_pkg::MUL_GAIN_HI;
                cmd.ld_lo   = 1'b1;
                state_next  = vsp_pkg::ST_GAIN_SUM;
            end
            vsp_pkg::ST_GAIN_SUM:
            begin
                cmd.ld_scale = 1'b1;
                state_next   = vsp_pkg::ST_OUT;
            end
            vsp_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = vsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/vsp_datapath.sv =====
// config registers, sample store, interpolation and mix arithmetic
module vsp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_accept,
    input  vsp_pkg::op_t                      in_op,
    input  logic [15:0]                       in_sample_address,
    input  logic signed [15:0]                in_sample_value,
    input  logic signed [15:0]                in_mix_left,
    input  logic signed [15:0]                in_mix_right,
    input  logic [31:0]                       in_timeline_position,
    input  vsp_pkg::cmd_t                     cmd,
    output vsp_pkg::status_t                  status,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [15:0]                out_mix_left,
    output logic signed [15:0]                out_mix_right,
    output logic                              out_clip_sounding
);

    localparam int SB = vsp_pkg::SAMPLE_BITS;

    // configuration
    logic [16:0] gain_reg;
    logic [15:0] pitch_reg;
    logic [16:0] count_reg;
    logic [31:0] clip_start_reg;
    logic [16:0] clip_length_reg;
    logic        enable_reg;

    logic [31:0] pos_reg;

    // request payload
    logic signed [15:0] mix_l_reg;
    logic signed [15:0] mix_r_reg;
    logic [31:0]        target_reg;

    // seek
    logic [32:0] seek_diff;
    logic [31:0] offset_reg;
    logic        before_reg;
    logic        in_clip;
    logic [31:0] last_idx;
    logic [31:0] seek_pos;

    // render
    logic [16:0] n_eff;
    logic [16:0] idx17;
    logic [16:0] gain_eff;
    logic [15:0] pitch_eff;
    logic [16:0] frac_inv;
    logic        sound_comb;
    logic        sound_reg;

    logic signed [SB-1:0] mem [vsp_pkg::STORE_DEPTH];
    logic signed [SB-1:0] rdata_reg;
    logic signed [SB-1:0] s0_reg;
    logic [31:0]          wr_addr32;
    logic [31:0]          rd_addr32;

    logic signed [vsp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [vsp_pkg::MUL_B_W-1:0] mul_b;
    logic signed [vsp_pkg::PROD_W-1:0]  prod_comb;
    logic signed [vsp_pkg::PROD_W-1:0]  prod_reg;
    logic signed [vsp_pkg::PROD_W-1:0]  lo_reg;
    logic signed [vsp_pkg::Q16_W-1:0]   acc_reg;
    logic signed [vsp_pkg::TOTAL_W-1:0] total;
    logic signed [SB+2:0]               scale_reg;

    logic signed [31:0] sum_l;
    logic signed [31:0] sum_r;
    logic signed [31:0] scale_ext;
    logic [32:0]        pos_sum;
    logic [31:0]        pos_adv;

    logic               out_valid_reg;
    logic signed [15:0] out_l_reg;
    logic signed [15:0] out_r_reg;
    logic               out_snd_reg;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // index to Q16.16 position, saturating
    function automatic logic [31:0] idx_to_pos(input logic [31:0] v);
        return (v[31:16] != 16'd0) ? 32'hFFFF_FFFF : {v[15:0], 16'h0000};
    endfunction

    assign n_eff = (32'(count_reg) > 32'(vsp_pkg::STORE_DEPTH))
                 ? 17'(vsp_pkg::STORE_DEPTH) : count_reg;
    assign idx17     = {1'b0, pos_reg[31:16]};
    assign gain_eff  = (gain_reg > vsp_pkg::GAIN_MAX) ? vsp_pkg::GAIN_MAX : gain_reg;
    assign pitch_eff = (pitch_reg < vsp_pkg::PITCH_MIN) ? vsp_pkg::PITCH_MIN
                     : (pitch_reg > vsp_pkg::PITCH_MAX) ? vsp_pkg::PITCH_MAX : pitch_reg;
    assign frac_inv  = 17'h10000 - {1'b0, pos_reg[15:0]};

    always_comb
    begin
        if (!enable_reg || n_eff == 17'd0)
        begin
            sound_comb = 1'b0;
        end
        else if (pitch_reg == vsp_pkg::PITCH_UNITY)
        begin
            sound_comb = idx17 < n_eff;
        end
        else
        begin
            sound_comb = (idx17 + 17'd1) < n_eff;
        end
    end

    assign status.sound    = sound_comb;
    assign status.unity    = pitch_reg == vsp_pkg::PITCH_UNITY;
    assign status.out_free = !out_valid_reg || out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= 17'd16384;
            pitch_reg       <= vsp_pkg::PITCH_UNITY;
            count_reg       <= '0;
            clip_start_reg  <= '0;
            clip_length_reg <= '0;
            enable_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vsp_pkg::CFG_GAIN:         gain_reg        <= cfg_data[16:0];
                vsp_pkg::CFG_PITCH:        pitch_reg       <= cfg_data[15:0];
                vsp_pkg::CFG_SAMPLE_COUNT: count_reg       <= cfg_data[16:0];
                vsp_pkg::CFG_CLIP_START:   clip_start_reg  <= cfg_data[31:0];
                vsp_pkg::CFG_CLIP_LENGTH:  clip_length_reg <= cfg_data[16:0];
                vsp_pkg::CFG_PLAY_ENABLE:  enable_reg      <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // sample store, single port
    assign wr_addr32 = 32'(in_sample_address);
    assign rd_addr32 = 32'(pos_reg[31:16]) + 32'(cmd.rd_next);

    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == vsp_pkg::OP_WRITE
            && wr_addr32 < 32'(vsp_pkg::STORE_DEPTH))
        begin
            mem[wr_addr32[vsp_pkg::ADDR_W-1:0]] <= vsp_pkg::sat_sample(in_sample_value);
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr32[vsp_pkg::ADDR_W-1:0]];
        end
    end

    // seek arithmetic
    assign seek_diff = {1'b0, target_reg} - {1'b0, clip_start_reg};
    assign in_clip   = (offset_reg < 32'(clip_length_reg)) && (offset_reg < 32'(n_eff));
    assign last_idx  = 32'(n_eff) - 32'd1;

    always_comb
    begin
        if (before_reg)
        begin
            seek_pos = '0;
        end
        else if (in_clip)
        begin
            seek_pos = idx_to_pos(offset_reg);
        end
        else if (n_eff == 17'd0)
        begin
            seek_pos = '0;
        end
        else
        begin
            seek_pos = idx_to_pos(last_idx);
        end
    end

    // shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            vsp_pkg::MUL_S0:
            begin
                mul_a = vsp_pkg::MUL_A_W'(s0_reg);
                mul_b = $signed({1'b0, frac_inv});
            end
            vsp_pkg::MUL_S1:
            begin
                mul_a = vsp_pkg::MUL_A_W'(rdata_reg);
                mul_b = $signed({2'b00, pos_reg[15:0]});
            end
            vsp_pkg::MUL_GAIN_LO:
            begin
                mul_a = $signed(vsp_pkg::MUL_A_W'(acc_reg[15:0]));
                mul_b = $signed({1'b0, gain_eff});
            end
            vsp_pkg::MUL_GAIN_HI:
            begin
                mul_a = vsp_pkg::MUL_A_W'(acc_reg >>> 16);
                mul_b = $signed({1'b0, gain_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_comb = vsp_pkg::PROD_W'(mul_a) * vsp_pkg::PROD_W'(mul_b);

    // high partial product shifted up, low one added, then round at 2^-30
    assign total = (vsp_pkg::TOTAL_W'(prod_reg) <<< 16)
                 + vsp_pkg::TOTAL_W'(lo_reg)
                 + (vsp_pkg::TOTAL_W'(1) <<< 29);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mix_l_reg  <= in_mix_left;
            mix_r_reg  <= in_mix_right;
            target_reg <= in_timeline_position;
        end
        if (cmd.seek_sub)
        begin
            offset_reg <= seek_diff[31:0];
            before_reg <= seek_diff[32];
        end
        if (cmd.ld_sound)
        begin
            sound_reg <= sound_comb;
        end
        if (cmd.ld_s0)
        begin
            s0_reg <= rdata_reg;
        end
        if (cmd.mul_sel != vsp_pkg::MUL_NONE)
        begin
            prod_reg <= prod_comb;
        end
        unique case (cmd.acc_sel)
            vsp_pkg::ACC_UNITY: acc_reg <= vsp_pkg::Q16_W'(rdata_reg) <<< 16;
            vsp_pkg::ACC_LOAD:  acc_reg <= vsp_pkg::Q16_W'(prod_reg);
            vsp_pkg::ACC_ADD:   acc_reg <= acc_reg + vsp_pkg::Q16_W'(prod_reg);
            default:            ;
        endcase
        if (cmd.ld_lo)
        begin
            lo_reg <= prod_reg;
        end
        if (cmd.ld_scale)
        begin
            scale_reg <= total[SB+32:30];
        end
    end

    // mix and position advance
    assign scale_ext = sound_reg ? 32'(scale_reg) : 32'sd0;
    assign sum_l     = 32'(mix_l_reg) + scale_ext;
    assign sum_r     = 32'(mix_r_reg) + scale_ext;
    assign pos_sum   = {1'b0, pos_reg} + 33'({pitch_eff, 2'b00});
    assign pos_adv   = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.seek_set)
        begin
            pos_reg <= seek_pos;
        end
        else if (cmd.out_load && sound_reg)
        begin
            pos_reg <= pos_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_l_reg   <= sat16(sum_l);
            out_r_reg   <= sat16(sum_r);
            out_snd_reg <= sound_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_mix_left      = out_l_reg;
    assign out_mix_right     = out_r_reg;
    assign out_clip_sounding = out_snd_reg;

endmodule

// ===== bench/vsp_mix_checker.sv =====
// checker for the varispeed sample player: predicts each mix frame and compares results
module vsp_mix_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [vsp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [vsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [vsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            run_done,
    output int                              outstanding,
    output int                              fail_count,
    output int                              frames_checked,
    output int                              frames_sounding,
    output int                              frames_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    // request fields, lowest bits last
    typedef struct packed {
        logic [31:0]        timeline;
        logic signed [15:0] mix_right;
        logic signed [15:0] mix_left;
        logic signed [15:0] value;
        logic [15:0]        addr;
        vsp_pkg::op_t       op;
    } request_t;

    typedef struct packed {
        logic               sounding;
        logic signed [15:0] right;
        logic signed [15:0] left;
    } frame_t;

    logic signed [15:0] sample_mem [0:vsp_pkg::STORE_DEPTH-1];
    logic [31:0]        play_pos;
    logic [16:0]        gain_reg;
    logic [15:0]        pitch_reg;
    logic [16:0]        count_reg;
    logic [31:0]        start_reg;
    logic [16:0]        length_reg;
    logic               enable_reg;

    frame_t             expected_frames [$];
    request_t           req;
    frame_t             predicted;
    frame_t             got;
    frame_t             want;
    bit                 leftovers_done;

    task automatic report_mismatch(input string field, input longint got_value,
                                   input longint want_value);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field,
                 got_value, want_value);
        fail_count++;
    endtask

    function automatic logic [16:0] live_count();
        return (count_reg > 17'(vsp_pkg::STORE_DEPTH)) ? 17'(vsp_pkg::STORE_DEPTH)
                                                        : count_reg;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    task automatic apply_seek(input logic [31:0] target);
        logic [16:0] n;
        longint      offset;
        logic [31:0] last_idx;
        n = live_count();
        last_idx = 32'(n) - 32'd1;
        if (target < start_reg)
        begin
            play_pos = 32'd0;
        end
        else
        begin
            offset = longint'(target) - longint'(start_reg);
            if (offset < longint'(length_reg) && offset < longint'(n))
            begin
                play_pos = 32'(offset) << 16;
            end
            else
            begin
                play_pos = (n != 0) ? (last_idx << 16) : 32'd0;
            end
        end
    endtask

    task automatic render_frame(input request_t r, output frame_t frame);
        logic [16:0] n;
        logic [16:0] g;
        logic [15:0] p;
        logic [31:0] idx;
        logic [31:0] frac;
        logic        sounding;
        longint      q16;
        longint      acc;
        longint      contrib;
        longint      left_sum;
        longint      right_sum;
        longint      next_pos;
        n = live_count();
        g = (gain_reg > vsp_pkg::GAIN_MAX) ? vsp_pkg::GAIN_MAX : gain_reg;
        p = (pitch_reg < vsp_pkg::PITCH_MIN) ? vsp_pkg::PITCH_MIN :
            ((pitch_reg > vsp_pkg::PITCH_MAX) ? vsp_pkg::PITCH_MAX : pitch_reg);
        idx = {16'd0, play_pos[31:16]};
        frac = {16'd0, play_pos[15:0]};
        sounding = 1'b0;
        q16 = 0;
        left_sum = longint'(r.mix_left);
        right_sum = longint'(r.mix_right);
        if (enable_reg && n != 0)
        begin
            if (p == vsp_pkg::PITCH_UNITY)
            begin
                if (idx < 32'(n))
                begin
                    q16 = longint'(sample_mem[idx]) * 65536;
                    sounding = 1'b1;
                end
            end
            else if (idx + 32'd1 < 32'(n))
            begin
                // linear blend of the two neighbor samples in Q16
                q16 = longint'(sample_mem[idx]) * (65536 - longint'(frac))
                    + longint'(sample_mem[idx + 32'd1]) * longint'(frac);
                sounding = 1'b1;
            end
        end
        if (sounding)
        begin
            acc = q16 * longint'(g) + (longint'(1) << 29);
            contrib = acc >>> 30;
            left_sum = left_sum + contrib;
            right_sum = right_sum + contrib;
            if (left_sum > 32767 || left_sum < -32768 || right_sum > 32767
                || right_sum < -32768)
            begin
                frames_clipped++;
            end
            next_pos = longint'(play_pos) + longint'(p) * 4;
            play_pos = (next_pos > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : next_pos[31:0];
        end
        frame.left = clip16(left_sum);
        frame.right = clip16(right_sum);
        frame.sounding = sounding;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_pos = 32'd0;
            gain_reg = 17'd16384;
            pitch_reg = vsp_pkg::PITCH_UNITY;
            count_reg = 17'd0;
            start_reg = 32'd0;
            length_reg = 17'd0;
            enable_reg = 1'b0;
            expected_frames.delete();
            outstanding = 0;
            fail_count = 0;
            frames_checked = 0;
            frames_sounding = 0;
            frames_clipped = 0;
            leftovers_done = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (vsp_pkg::cfg_idx_t'(cfg_index))
                    vsp_pkg::CFG_GAIN:         gain_reg = cfg_data[16:0];
                    vsp_pkg::CFG_PITCH:        pitch_reg = cfg_data[15:0];
                    vsp_pkg::CFG_SAMPLE_COUNT: count_reg = cfg_data[16:0];
                    vsp_pkg::CFG_CLIP_START:   start_reg = cfg_data;
                    vsp_pkg::CFG_CLIP_LENGTH:  length_reg = cfg_data[16:0];
                    vsp_pkg::CFG_PLAY_ENABLE:  enable_reg = cfg_data[0];
                    default:                   ;
                endcase
            end
            // results first, so a frame never answers a request of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = frame_t'(m_axis_tdata[32:0]);
                if (expected_frames.size() == 0)
                begin
                    report_mismatch("result with no request pending", got, 0);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (want.sounding)
                    begin
                        frames_sounding++;
                    end
                    if (got.left !== want.left)
                    begin
                        report_mismatch("mix_left_out", got.left, want.left);
                    end
                    if (got.right !== want.right)
                    begin
                        report_mismatch("mix_right_out", got.right, want.right);
                    end
                    if (got.sounding !== want.sounding)
                    begin
                        report_mismatch("clip_sounding", got.sounding, want.sounding);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                req = request_t'(s_axis_tdata[97:0]);
                case (req.op)
                    vsp_pkg::OP_WRITE:  sample_mem[req.addr] = vsp_pkg::sat_sample(req.value);
                    vsp_pkg::OP_SEEK:   apply_seek(req.timeline);
                    vsp_pkg::OP_RENDER:
                    begin
                        render_frame(req, predicted);
                        expected_frames.push_back(predicted);
                    end
                    default:            ;
                endcase
            end
            outstanding = expected_frames.size();
            if (run_done && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (expected_frames.size() != 0)
                begin
                    report_mismatch("frames never delivered", 0, expected_frames.size());
                end
            end
        end
    end

endmodule

// ===== bench/tb_varispeed_sample_player_core.sv =====
// stimulus, clocking and verdict for the varispeed sample player regression
module tb_varispeed_sample_player_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW     = 32;    // entries 0..31 always loaded
    localparam int RUN_MAX    = 8;     // renders allowed between seeks
    localparam int SEEK_REACH = 14;    // seek offsets from the clip start below this are safe
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 16;
    localparam int HOLD_OFF   = 200;
    localparam logic [vsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [vsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int MODE_FREE    = 0;
    localparam int MODE_SENDER  = 1;
    localparam int MODE_RECEIVE = 2;
    localparam int MODE_BOTH    = 3;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [vsp_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [vsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            cfg_we;
    logic [vsp_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [vsp_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            run_done;

    int                     outstanding;
    int                     fail_count;
    int                     frames_checked;
    int                     frames_sounding;
    int                     frames_clipped;

    int                     sender_idle_pct;
    int                     receiver_stall_pct;
    int                     hold_cycles;
    int                     renders_since_seek;
    int                     settings_used;
    logic [16:0]            cur_count;
    logic [16:0]            cur_length;
    logic [31:0]            cur_start;

    varispeed_sample_player_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vsp_mix_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .outstanding     (outstanding),
        .fail_count      (fail_count),
        .frames_checked  (frames_checked),
        .frames_sounding (frames_sounding),
        .frames_clipped  (frames_clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stalls, plus a long hold-off on demand
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("varispeed_sample_player_core regression: fail");
        $finish;
    end

    function automatic logic [15:0] pick_sample();
        int roll;
        roll = $urandom_range(7);
        if (roll == 0)
        begin
            return 16'h7FFF;
        end
        if (roll == 1)
        begin
            return 16'h8000;
        end
        return 16'($urandom());
    endfunction

    function automatic logic [16:0] live_count();
        return (cur_count > 17'(vsp_pkg::STORE_DEPTH)) ? 17'(vsp_pkg::STORE_DEPTH)
                                                        : cur_count;
    endfunction

    // a seek must never leave the play position over entries that were never loaded
    function automatic bit seek_is_safe(input logic [31:0] target);
        longint n;
        longint offset;
        longint reach;
        n = longint'(live_count());
        if (target < cur_start || n <= WINDOW)
        begin
            return 1'b1;
        end
        offset = longint'(target) - longint'(cur_start);
        reach = (longint'(cur_length) < n) ? longint'(cur_length) : n;
        return (offset >= reach) || (offset < SEEK_REACH);
    endfunction

    task automatic offer(input vsp_pkg::op_t op, input logic [15:0] addr,
                         input logic [15:0] value, input logic [15:0] left,
                         input logic [15:0] right, input logic [31:0] timeline);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, timeline, right, left, value, addr, op};
        do @(posedge clk); while (!s_axis_tready);
        if (op == vsp_pkg::OP_RENDER)
        begin
            renders_since_seek++;
        end
        if (op == vsp_pkg::OP_SEEK)
        begin
            renders_since_seek = 0;
        end
    endtask

    task automatic offer_seek();
        logic [31:0] target;
        int          kind;
        kind = $urandom_range(2);
        if (kind == 0)
        begin
            target = cur_start + 32'($urandom_range(0, SEEK_REACH - 1));
            if (target < cur_start)
            begin
                target = cur_start;
            end
        end
        else if (kind == 1 && cur_start != 0)
        begin
            target = $urandom_range(0, cur_start - 1);
        end
        else
        begin
            target = $urandom();
        end
        if (!seek_is_safe(target))
        begin
            target = cur_start;
        end
        offer(vsp_pkg::OP_SEEK, 16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), target);
    endtask

    task automatic offer_render(input logic [15:0] left, input logic [15:0] right);
        offer(vsp_pkg::OP_RENDER, 16'($urandom()), 16'($urandom()), left, right, $urandom());
    endtask

    task automatic offer_write(input logic [15:0] addr, input logic [15:0] value);
        offer(vsp_pkg::OP_WRITE, addr, value, 16'($urandom()), 16'($urandom()), $urandom());
    endtask

    task automatic write_reg(input logic [vsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // wait for every frame in flight, then let a trailing seek or write finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input logic [16:0] gain, input logic [15:0] pitch,
                             input logic [16:0] count, input logic [31:0] start,
                             input logic [16:0] length, input logic enable,
                             input int mode, input int items, input bit squeeze);
        int          k;
        int          roll;
        logic [16:0] n;
        settle();
        sender_idle_pct = (mode == MODE_SENDER) ? 54 : ((mode == MODE_BOTH) ? 37 : 0);
        receiver_stall_pct = (mode == MODE_RECEIVE) ? 54 : ((mode == MODE_BOTH) ? 37 : 0);
        // junk above each register width must be dropped
        write_reg(vsp_pkg::CFG_GAIN, {15'($urandom()), gain});
        write_reg(vsp_pkg::CFG_PITCH, {16'($urandom()), pitch});
        write_reg(vsp_pkg::CFG_SAMPLE_COUNT, {15'($urandom()), count});
        write_reg(vsp_pkg::CFG_CLIP_START, start);
        write_reg(vsp_pkg::CFG_CLIP_LENGTH, {15'($urandom()), length});
        write_reg(vsp_pkg::CFG_PLAY_ENABLE, {31'($urandom()), enable});
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(CFG_SPARE_HI, $urandom());
        cfg_we <= 1'b0;
        cur_count = count;
        cur_start = start;
        cur_length = length;
        settings_used++;
        n = live_count();
        if (n > WINDOW)
        begin
            offer_write(16'(n - 17'd2), pick_sample());
            offer_write(16'(n - 17'd1), pick_sample());
        end
        offer(vsp_pkg::OP_SEEK, 16'd0, 16'd0, 16'd0, 16'd0, start);
        if (squeeze)
        begin
            hold_cycles = HOLD_OFF;
        end
        for (k = 0; k < items; k++)
        begin
            roll = $urandom_range(99);
            if (renders_since_seek >= RUN_MAX || roll < 10)
            begin
                offer_seek();
            end
            else if (roll < 24)
            begin
                offer_write(roll[0] ? 16'($urandom_range(0, WINDOW - 1)) : 16'($urandom()),
                            pick_sample());
            end
            else if (roll < 28)
            begin
                offer(vsp_pkg::OP_NOP, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), $urandom());
            end
            else
            begin
                offer_render(pick_sample(), pick_sample());
            end
        end
    endtask

    initial
    begin
        int          a;
        int          ph;
        logic [16:0] rnd_count;
        logic [31:0] rnd_start;
        logic [15:0] rnd_pitch;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        run_done = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_cycles = 0;
        renders_since_seek = 0;
        settings_used = 0;
        cur_count = 17'd0;
        cur_length = 17'd0;
        cur_start = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: player off, mix passes through; store address extremes
        offer_render(16'h7FFF, 16'h8000);
        offer(vsp_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        offer(vsp_pkg::OP_SEEK, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
        offer_write(16'hFFFF, 16'h8000);
        for (a = 0; a < WINDOW; a++)
        begin
            offer_write(16'(a), (a < 2) ? 16'h7FFF : ((a < 4) ? 16'h8000 : pick_sample()));
        end

        // unity pitch reads samples directly, saturating both ways
        run_phase(17'd16384, vsp_pkg::PITCH_UNITY, 17'd32, 32'd0, 17'd32, 1'b1, MODE_FREE,
                  0, 1'b0);
        offer_render(16'h7FFF, 16'h7FFF);
        offer_render(16'h8000, 16'h8000);
        offer_render(16'h8000, 16'h0000);

        // gain 4.0 and pitch 2.0; seeks before, inside and past the clip
        run_phase(vsp_pkg::GAIN_MAX, vsp_pkg::PITCH_MAX, 17'd32, 32'd100, 17'd20, 1'b1,
                  MODE_FREE, 0, 1'b0);
        offer(vsp_pkg::OP_SEEK, 16'd0, 16'd0, 16'd0, 16'd0, 32'd99);
        offer_render(16'h0000, 16'h0000);
        offer(vsp_pkg::OP_SEEK, 16'd0, 16'd0, 16'd0, 16'd0, 32'd119);
        offer_render(16'h0100, 16'hFF00);
        offer(vsp_pkg::OP_SEEK, 16'd0, 16'd0, 16'd0, 16'd0, 32'd120);
        offer_render(16'h1234, 16'h4321);
        offer(vsp_pkg::OP_SEEK, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);

        // pitch 0.5 walks half-way between neighbors
        run_phase(17'd16384, vsp_pkg::PITCH_MIN, 17'd32, 32'd0, 17'd65536, 1'b1, MODE_FREE,
                  0, 1'b0);
        offer_render(16'h0000, 16'h0000);
        offer_render(16'h0000, 16'h0000);
        offer_render(16'h0000, 16'h0000);

        run_phase(17'd16384, vsp_pkg::PITCH_UNITY, 17'd32, 32'd0, 17'd32, 1'b1, MODE_FREE,
                  30, 1'b0);
        run_phase(vsp_pkg::GAIN_MAX, vsp_pkg::PITCH_MAX, 17'd32, 32'd100, 17'd20, 1'b1,
                  MODE_SENDER, 30, 1'b0);
        run_phase(17'd0, vsp_pkg::PITCH_MIN, 17'd32, 32'hFFFF_FFF0, 17'd65536, 1'b1,
                  MODE_RECEIVE, 30, 1'b0);
        run_phase(17'h1FFFF, 16'd0, 17'd65536, 32'd12345, 17'd0, 1'b1, MODE_BOTH, 30, 1'b0);
        run_phase(17'd20000, 16'hFFFF, 17'h1FFFF, 32'd0, 17'd100, 1'b1, MODE_FREE, 40, 1'b1);
        run_phase(17'($urandom()), vsp_pkg::PITCH_UNITY, 17'd0, $urandom_range(0, 500),
                  17'd40, 1'b1, MODE_SENDER, 20, 1'b0);
        run_phase(17'($urandom()), vsp_pkg::PITCH_UNITY, 17'd1, 32'd0, 17'd1, 1'b1,
                  MODE_RECEIVE, 20, 1'b0);
        run_phase(17'($urandom()), 16'($urandom()), 17'd32, 32'd0, 17'd32, 1'b0, MODE_BOTH,
                  20, 1'b0);
        for (ph = 0; ph < 4; ph++)
        begin
            rnd_count = ($urandom_range(3) == 0) ? 17'd65536 : 17'($urandom_range(2, WINDOW));
            rnd_start = $urandom_range(1) ? 32'($urandom_range(0, 1000)) : $urandom();
            rnd_pitch = $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(8192, 32768));
            run_phase(17'($urandom_range(0, 131071)), rnd_pitch, rnd_count, rnd_start,
                      17'($urandom_range(0, 65536)), 1'b1, ph, 30, 1'b0);
        end

        settle();
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("covered %0d mix frames under %0d register settings and four idle patterns",
                 frames_checked, settings_used);
        $display("%0d frames carried clip audio, %0d of them hit 16-bit saturation",
                 frames_sounding, frames_clipped);
        if (fail_count == 0)
        begin
            $display("varispeed_sample_player_core regression: pass");
        end
        else
        begin
            $display("varispeed_sample_player_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vsp_pkg.sv
src/vsp_ctrl.sv
src/vsp_datapath.sv
src/varispeed_sample_player_core.sv
bench/vsp_mix_checker.sv
bench/tb_varispeed_sample_player_core.sv
